### rtl/mbrh_pkg.sv
// shared types, constants and sequencer states for the read holding registers responder
package mbrh_pkg;

    localparam int unsigned FRAME_LEN       = 8;
    localparam int unsigned POS_W           = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);
    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned MAX_REGS_DEF    = 16;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] TABLE_RESET     = 16'h0005;
    localparam logic [7:0]  FUNC_READ_HOLD  = 8'h03;
    localparam logic [7:0]  SLAVE_ID_RESET  = 8'h01;

    localparam logic KIND_RX_BYTE = 1'b0;
    localparam logic KIND_TABLE   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ID,
        ST_FUNC,
        ST_BCNT,
        ST_RD,
        ST_DHI,
        ST_DLO,
        ST_CRCLO,
        ST_CRCHI
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
        logic [5:0]  reg_index;
        logic [15:0] reg_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       init;
        logic       start;
        logic [7:0] data;
    } crc_ctrl_t;

endpackage

### rtl/mbrh_ram.sv
// generic single write port ram with registered read
module mbrh_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mbrh_crc.sv
// bit-serial crc-16/modbus unit, one shift per cycle
module mbrh_crc (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbrh_pkg::crc_ctrl_t ctrl,
    output logic [15:0]         crc,
    output logic                busy
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;

    always_comb begin
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.init) begin
            crc_next = mbrh_pkg::CRC_INIT;
        end else if (ctrl.start) begin
            crc_next  = crc_reg ^ {8'h00, ctrl.data};
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (crc_reg[0]) begin
                crc_next = (crc_reg >> 1) ^ mbrh_pkg::CRC_POLY;
            end else begin
                crc_next = crc_reg >> 1;
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= mbrh_pkg::CRC_INIT;
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign crc  = crc_reg;
    assign busy = busy_reg;

endmodule

### rtl/modbus_rtu_read_holding_responder_top.sv
// Modbus RTU slave answering read holding registers (function 3). An input item
// is either a received serial byte or a write of one holding register; each is
// taken while the block is idle. The eighth byte of a request addressed to this
// slave starts the request check, and a valid request starts a response: every
// byte covered by the CRC passes through a shared bit-serial CRC unit, and the
// next byte waits until the unit has finished shifting; the table read for each
// register overlaps that shifting. No item is taken while a response is built,
// also while the result side stalls. Table entries not yet written read as five.
module modbus_rtu_read_holding_responder_top #(
    parameter int unsigned TABLE_DEPTH = mbrh_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_REGS    = mbrh_pkg::MAX_REGS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbrh_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mbrh_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);

    localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(MAX_REGS + 1);
    localparam int unsigned SW  = 9;

    mbrh_pkg::state_t    state_reg, state_next;
    mbrh_pkg::out_item_t out_reg, out_next;
    mbrh_pkg::crc_ctrl_t crc_ctrl;

    logic [7:0]              slave_id_reg;
    logic [7:0]              rx_frame_reg [mbrh_pkg::FRAME_LEN];
    logic [mbrh_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]              addr_reg, addr_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic                    m_valid_reg;
    logic                    out_load;
    logic                    frame_we;
    logic                    ram_we;
    logic                    ram_re;
    logic                    valid_reg [TABLE_DEPTH];
    logic                    rd_valid_reg;
    logic [15:0]             ram_q;
    logic [15:0]             word;
    logic [15:0]             crc;
    logic                    crc_busy;
    logic                    can_send;
    logic [7:0]              id_byte;
    logic [SW-1:0]           wr_index;
    logic [SW-1:0]           req_end;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;

    assign wr_index = {3'b000, s_data.reg_index};
    assign wr_addr  = wr_index[AW-1:0];
    assign rd_addr  = addr_reg[AW-1:0];
    assign req_end  = {1'b0, rx_frame_reg[3]} + {1'b0, rx_frame_reg[5]};
    assign word     = rd_valid_reg ? ram_q : mbrh_pkg::TABLE_RESET;
    assign can_send = (!m_valid_reg || m_ready) && !crc_busy;
    assign id_byte  = (pos_reg == '0) ? s_data.rx_byte : rx_frame_reg[0];
    assign s_ready  = (state_reg == mbrh_pkg::ST_IDLE);

    mbrh_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wr_addr),
        .wdata(s_data.reg_value),
        .re   (ram_re),
        .raddr(rd_addr),
        .rdata(ram_q)
    );

    mbrh_crc u_crc (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (crc_ctrl),
        .crc    (crc),
        .busy   (crc_busy)
    );

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        out_load      = 1'b0;
        out_next      = out_reg;
        frame_we      = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        crc_ctrl      = '0;
        case (state_reg)
            mbrh_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.kind == mbrh_pkg::KIND_TABLE) begin
                        ram_we = (wr_index < SW'(TABLE_DEPTH));
                    end else begin
                        frame_we = 1'b1;
                        if (id_byte == slave_id_reg) begin
                            if (pos_reg == mbrh_pkg::POS_LAST) begin
                                pos_next   = '0;
                                state_next = mbrh_pkg::ST_CHECK;
                            end else begin
                                pos_next = pos_reg + mbrh_pkg::POS_W'(1);
                            end
                        end else begin
                            pos_next = '0;
                        end
                    end
                end
            end
            mbrh_pkg::ST_CHECK: begin
                if (rx_frame_reg[1] == mbrh_pkg::FUNC_READ_HOLD &&
                    rx_frame_reg[5] != 8'd0 &&
                    rx_frame_reg[5] <= 8'(MAX_REGS) &&
                    req_end <= SW'(TABLE_DEPTH)) begin
                    crc_ctrl.init = 1'b1;
                    addr_next     = rx_frame_reg[3];
                    rem_next      = rx_frame_reg[5][CW-1:0];
                    state_next    = mbrh_pkg::ST_ID;
                end else begin
                    state_next = mbrh_pkg::ST_IDLE;
                end
            end
            mbrh_pkg::ST_ID: begin
                if (can_send) begin
                    out_load       = 1'b1;
                    out_next       = '{tx_byte: slave_id_reg, last: 1'b0};
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.data  = slave_id_reg;
                    state_next     = mbrh_pkg::ST_FUNC;
                end
            end
            mbrh_pkg::ST_FUNC: begin
                if (can_send) begin
                    out_load       = 1'b1;
                    out_next       = '{tx_byte: mbrh_pkg::FUNC_READ_HOLD, last: 1'b0};
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.data  = mbrh_pkg::FUNC_READ_HOLD;
                    state_next     = mbrh_pkg::ST_BCNT;
                end
            end
            mbrh_pkg::ST_BCNT: begin
                if (can_send) begin
                    out_load       = 1'b1;
                    out_next       = '{tx_byte: {rx_frame_reg[5][6:0], 1'b0}, last: 1'b0};
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.data  = {rx_frame_reg[5][6:0], 1'b0};
                    state_next     = mbrh_pkg::ST_RD;
                end
            end
            mbrh_pkg::ST_RD: begin
                ram_re     = 1'b1;
                state_next = mbrh_pkg::ST_DHI;
            end
            mbrh_pkg::ST_DHI: begin
                if (can_send) begin
                    out_load       = 1'b1;
                    out_next       = '{tx_byte: word[15:8], last: 1'b0};
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.data  = word[15:8];
                    state_next     = mbrh_pkg::ST_DLO;
                end
            end
            mbrh_pkg::ST_DLO: begin
                if (can_send) begin
                    out_load       = 1'b1;
                    out_next       = '{tx_byte: word[7:0], last: 1'b0};
                    crc_ctrl.start = 1'b1;
                    crc_ctrl.data  = word[7:0];
                    addr_next      = addr_reg + 8'd1;
                    rem_next       = rem_reg - CW'(1);
                    if (rem_reg == CW'(1)) begin
                        state_next = mbrh_pkg::ST_CRCLO;
                    end else begin
                        state_next = mbrh_pkg::ST_RD;
                    end
                end
            end
            mbrh_pkg::ST_CRCLO: begin
                if (can_send) begin
                    out_load   = 1'b1;
                    out_next   = '{tx_byte: crc[7:0], last: 1'b0};
                    state_next = mbrh_pkg::ST_CRCHI;
                end
            end
            mbrh_pkg::ST_CRCHI: begin
                if (can_send) begin
                    out_load   = 1'b1;
                    out_next   = '{tx_byte: crc[15:8], last: 1'b1};
                    state_next = mbrh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mbrh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mbrh_pkg::ST_IDLE;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
            slave_id_reg <= mbrh_pkg::SLAVE_ID_RESET;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                slave_id_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (ram_we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        if (out_load) begin
            out_reg <= out_next;
        end
        if (frame_we) begin
            rx_frame_reg[pos_reg] <= s_data.rx_byte;
        end
        if (ram_re) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("waiting item dropped or changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !crc_busy)
        else $error("crc unit still folding while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbrh_pkg::ST_RD) |-> ({1'b0, addr_reg} < SW'(TABLE_DEPTH)))
        else $error("table read beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbrh_pkg::ST_DLO) |-> (rem_reg != '0))
        else $error("register count underflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbrh_pkg::ST_CHECK) |=> !m_valid || $past(m_valid))
        else $error("item produced by the request check");

endmodule
